### sv/atte_pkg.sv
// Shared types, widths and the SGR color table for the ANSI text terminal engine.
package atte_pkg;

   localparam int CHAR_W     = 9;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int ATTR_W     = 8;
   localparam int TAB_W      = 4;
   localparam int PARAM_W    = 16;
   localparam int DIGIT_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [PARAM_W-1:0] PARAM_MAX = 16'hFFFF;

   // Control from the sequencer to the parameter registers.
   typedef struct packed {
      logic               clear;
      logic               digit_en;
      logic [DIGIT_W-1:0] digit;
      logic               semi_en;
      logic               walk_en;
   } param_ctrl_type;

   // Text attribute state that SGR codes act on.
   typedef struct packed {
      logic [ATTR_W-1:0] attr;
      logic              bold;
      logic              blink;
   } sgr_state_type;

   function automatic logic [3:0] sgr_color(input logic [2:0] idx);
      logic [3:0] color;
      unique case (idx)
         3'd0: color = 4'h0;
         3'd1: color = 4'h4;
         3'd2: color = 4'h2;
         3'd3: color = 4'hE;
         3'd4: color = 4'h1;
         3'd5: color = 4'h5;
         3'd6: color = 4'h3;
         3'd7: color = 4'h7;
         default: color = 4'h7;
      endcase
      return color;
   endfunction

endpackage

### sv/atte_if.sv
// Request and response channel interfaces of the ANSI text terminal engine.
interface atte_req_if import atte_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface atte_rsp_if import atte_pkg::*;;
   logic              valid;
   logic              ready;
   logic              cell_write;
   logic [ROW_W-1:0]  cell_row;
   logic [COL_W-1:0]  cell_col;
   logic [7:0]        cell_char;
   logic [ATTR_W-1:0] cell_attr;
   logic              scroll_up;
   logic              clear_screen;
   logic [ROW_W-1:0]  cursor_row_out;
   logic [COL_W-1:0]  cursor_col_out;

   modport source (output valid, output cell_write, output cell_row, output cell_col,
                   output cell_char, output cell_attr, output scroll_up,
                   output clear_screen, output cursor_row_out, output cursor_col_out,
                   input ready);
   modport sink   (input valid, input cell_write, input cell_row, input cell_col,
                   input cell_char, input cell_attr, input scroll_up,
                   input clear_screen, input cursor_row_out, input cursor_col_out,
                   output ready);
endinterface

### sv/ansi_text_terminal_engine_unit.sv
// Top level of the ANSI text terminal engine: sequencer, cursor rules and response register.
//
//   channel   dir  handshake            payload
//   req_chan  in   valid/ready          char_code
//   rsp_chan  out  valid/ready          cell write, scroll/clear requests, cursor
//   csr_*     in   csr_we (no stall)    csr_index, csr_wdata
//
// After a request is accepted the engine passes through an execute state and, for
// an SGR final ('m'), an SGR state that walks each collected parameter slot
// (1 to PARAM_SLOTS) through the single SGR unit, before response valid rises.
// One request is in flight at a time: req
// ready is low from accept until the response is taken, and the response holds
// while rsp ready is low. Reset is synchronous and clears cursor, attributes,
// parameter slots and the sequencer.
module ansi_text_terminal_engine_unit import atte_pkg::*; #(
   parameter int  COLUMNS     = 80,
   parameter int  ROWS        = 25,
   parameter int  PARAM_SLOTS = 10,
   localparam int IDX_W       = $clog2(PARAM_SLOTS),
   localparam int SU_W        = $clog2(PARAM_SLOTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   atte_req_if.sink              req_chan,
   atte_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SGR  = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   typedef struct packed {
      logic              cell_write;
      logic [ROW_W-1:0]  cell_row;
      logic [COL_W-1:0]  cell_col;
      logic [7:0]        cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic              scroll_up;
      logic              clear_screen;
   } result_type;

   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_ATTR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAB_STEP     = 1'd1;

   localparam logic [CHAR_W-1:0] CH_BS       = 9'h008;
   localparam logic [CHAR_W-1:0] CH_TAB      = 9'h009;
   localparam logic [CHAR_W-1:0] CH_LF       = 9'h00A;
   localparam logic [CHAR_W-1:0] CH_CR       = 9'h00D;
   localparam logic [CHAR_W-1:0] CH_ESC      = 9'h01B;
   localparam logic [CHAR_W-1:0] CH_ZERO     = 9'h030;
   localparam logic [CHAR_W-1:0] CH_NINE     = 9'h039;
   localparam logic [CHAR_W-1:0] CH_SEMI     = 9'h03B;
   localparam logic [CHAR_W-1:0] CH_UP       = 9'h041;
   localparam logic [CHAR_W-1:0] CH_DOWN     = 9'h042;
   localparam logic [CHAR_W-1:0] CH_FWD      = 9'h043;
   localparam logic [CHAR_W-1:0] CH_BACK     = 9'h044;
   localparam logic [CHAR_W-1:0] CH_HOME     = 9'h048;
   localparam logic [CHAR_W-1:0] CH_ERASE_SC = 9'h04A;
   localparam logic [CHAR_W-1:0] CH_LBRACKET = 9'h05B;
   localparam logic [CHAR_W-1:0] CH_SGR      = 9'h06D;
   localparam logic [CHAR_W-1:0] CH_LEFT     = 9'h0E4;
   localparam logic [CHAR_W-1:0] CH_RIGHT    = 9'h0E5;
   localparam logic [CHAR_W-1:0] CH_DELETE   = 9'h0E9;
   localparam logic [CHAR_W-1:0] CH_ERASE    = 9'h100;
   localparam logic [7:0]        CH_SPACE    = 8'h20;

   localparam logic [PARAM_W-1:0] ED_ALL    = 16'd2;
   localparam logic [ATTR_W-1:0]  ATTR_INIT = 8'h07;
   localparam logic [TAB_W-1:0]   TAB_INIT  = 4'd4;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W:0]   COL_ONE  = (COL_W+1)'(1);
   localparam logic [ROW_W:0]   ROW_ONE  = (ROW_W+1)'(1);
   localparam logic [COL_W:0]   COL_END  = (COL_W+1)'(COLUMNS);
   localparam logic [ROW_W:0]   ROW_END  = (ROW_W+1)'(ROWS);

   state_type          state_ff, state_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [IDX_W-1:0]   walk_idx_ff, walk_idx_in;
   logic               in_escape_ff, in_escape_in;
   logic               in_csi_ff, in_csi_in;
   sgr_state_type      sgr_ff, sgr_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [ATTR_W-1:0]  default_attr_ff, default_attr_in;
   logic [TAB_W-1:0]   tab_step_ff, tab_step_in;
   result_type         res_ff, res_in;

   param_ctrl_type     pctl;
   logic [PARAM_W-1:0] param_rd;
   logic [PARAM_W-1:0] param_first;
   logic [PARAM_W-1:0] param_second;
   logic [SU_W-1:0]    walk_count_ff, walk_count_in;
   sgr_state_type      sgr_next;
   logic               walk_last;
   logic               is_digit;

   // ordinary character path
   logic [COL_W:0]     ncol;
   logic [ROW_W:0]     nrow;
   logic               ord_wr;
   logic               ord_at_pre;
   logic [7:0]         ord_char;
   logic [COL_W-1:0]   ord_col;
   logic [ROW_W-1:0]   ord_row;
   result_type         ord_res;

   atte_param_regs #(.PARAM_SLOTS(PARAM_SLOTS)) u_params (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (pctl),
      .walk_idx     (walk_idx_ff),
      .rd_value     (param_rd),
      .first_value  (param_first),
      .second_value (param_second)
   );

   atte_sgr_unit u_sgr (
      .value        (param_rd),
      .cur          (sgr_ff),
      .default_attr (default_attr_ff),
      .nxt          (sgr_next)
   );

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = (state_ff == ST_RESP);
   assign rsp_chan.cell_write    = res_ff.cell_write;
   assign rsp_chan.cell_row      = res_ff.cell_row;
   assign rsp_chan.cell_col      = res_ff.cell_col;
   assign rsp_chan.cell_char     = res_ff.cell_char;
   assign rsp_chan.cell_attr     = res_ff.cell_attr;
   assign rsp_chan.scroll_up     = res_ff.scroll_up;
   assign rsp_chan.clear_screen  = res_ff.clear_screen;
   assign rsp_chan.cursor_row_out = cur_row_ff;
   assign rsp_chan.cursor_col_out = cur_col_ff;

   assign is_digit  = (char_ff >= CH_ZERO) && (char_ff <= CH_NINE);
   assign walk_last = (SU_W'(walk_idx_ff) + SU_W'(1)) == walk_count_ff;

   // Cell write and cursor rules for characters outside an escape sequence.
   always_comb begin
      ncol       = {1'b0, cur_col_ff};
      nrow       = {1'b0, cur_row_ff};
      ord_wr     = 1'b0;
      ord_at_pre = 1'b0;
      ord_char   = CH_SPACE;
      unique case (char_ff) inside
         CH_ERASE: begin
            if (cur_col_ff != '0) begin
               ncol = ncol - COL_ONE;
               if (ncol == '0 && cur_row_ff != '0) begin
                  ncol = {1'b0, COL_LAST};
                  nrow = nrow - ROW_ONE;
               end
               ord_wr = 1'b1;
            end
         end
         CH_LEFT: begin
            if (cur_col_ff != '0) ncol = ncol - COL_ONE;
         end
         CH_RIGHT: begin
            if (cur_col_ff != COL_LAST) ncol = ncol + COL_ONE;
         end
         CH_DELETE: begin
            ord_wr = 1'b1;
         end
         CH_LF, CH_CR: begin
            ncol = '0;
            nrow = nrow + ROW_ONE;
         end
         CH_TAB: begin
            ncol = ncol + {{(COL_W+1-TAB_W){1'b0}}, tab_step_ff};
            if (ncol >= COL_END) begin
               ncol = '0;
               nrow = nrow + ROW_ONE;
            end
         end
         CH_BS: begin
            if (cur_col_ff != '0) ncol = ncol - COL_ONE;
            ord_wr = 1'b1;
         end
         default: begin
            ord_wr     = 1'b1;
            ord_at_pre = 1'b1;
            ord_char   = char_ff[7:0];
            ncol       = ncol + COL_ONE;
            if (ncol >= COL_END) begin
               ncol = '0;
               nrow = nrow + ROW_ONE;
            end
         end
      endcase

      ord_res            = '0;
      ord_res.cell_write = ord_wr;
      if (ord_wr) begin
         ord_res.cell_char = ord_char;
         ord_res.cell_attr = sgr_ff.attr;
         ord_res.cell_row  = ord_at_pre ? cur_row_ff : nrow[ROW_W-1:0];
         ord_res.cell_col  = ord_at_pre ? cur_col_ff : ncol[COL_W-1:0];
      end
      ord_col = ncol[COL_W-1:0];
      ord_row = nrow[ROW_W-1:0];
      // past the bottom row: scroll and stay on the last row
      if (nrow >= ROW_END) begin
         ord_res.scroll_up = 1'b1;
         ord_row           = ROW_LAST;
      end
   end

   always_comb begin
      state_in        = state_ff;
      char_in         = char_ff;
      walk_idx_in     = walk_idx_ff;
      walk_count_in   = walk_count_ff;
      in_escape_in    = in_escape_ff;
      in_csi_in       = in_csi_ff;
      sgr_in          = sgr_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      default_attr_in = default_attr_ff;
      tab_step_in     = tab_step_ff;
      res_in          = res_ff;
      pctl            = '0;

      if (csr_we) begin
         unique case (csr_index)
            REG_DEFAULT_ATTR: default_attr_in = csr_wdata[ATTR_W-1:0];
            REG_TAB_STEP:     tab_step_in     = csr_wdata[TAB_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               char_in  = req_chan.char_code;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = '0;
            state_in = ST_RESP;
            if (char_ff > CH_ERASE) begin
               // out-of-range code: no state change
            end else if (char_ff == CH_ESC) begin
               pctl.clear   = 1'b1;
               in_escape_in = 1'b1;
               in_csi_in    = 1'b0;
            end else if (in_escape_ff && char_ff == CH_LBRACKET) begin
               pctl.clear = 1'b1;
               in_csi_in  = 1'b1;
            end else if (in_escape_ff && in_csi_ff) begin
               if (is_digit) begin
                  pctl.digit_en = 1'b1;
                  pctl.digit    = char_ff[DIGIT_W-1:0];
               end else if (char_ff == CH_SEMI) begin
                  pctl.semi_en = 1'b1;
               end else if (char_ff == CH_SGR) begin
                  walk_idx_in = '0;
                  state_in    = ST_SGR;
               end else begin
                  pctl.clear   = 1'b1;
                  in_escape_in = 1'b0;
                  in_csi_in    = 1'b0;
                  unique case (char_ff)
                     CH_UP: begin
                        if (cur_row_ff != '0) cur_row_in = cur_row_ff - ROW_W'(1);
                     end
                     CH_DOWN: begin
                        if (cur_row_ff != ROW_LAST) cur_row_in = cur_row_ff + ROW_W'(1);
                     end
                     CH_FWD: begin
                        if (cur_col_ff != COL_LAST) cur_col_in = cur_col_ff + COL_W'(1);
                     end
                     CH_BACK: begin
                        if (cur_col_ff != '0) cur_col_in = cur_col_ff - COL_W'(1);
                     end
                     CH_HOME: begin
                        cur_row_in = (param_first > PARAM_W'(ROWS - 1)) ? ROW_LAST
                                                                : param_first[ROW_W-1:0];
                        cur_col_in = (param_second > PARAM_W'(COLUMNS - 1)) ? COL_LAST
                                                                : param_second[COL_W-1:0];
                     end
                     CH_ERASE_SC: begin
                        if (param_first == ED_ALL) begin
                           res_in.clear_screen = 1'b1;
                           cur_row_in          = '0;
                           cur_col_in          = '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end else begin
               in_escape_in = 1'b0;
               in_csi_in    = 1'b0;
               cur_col_in   = ord_col;
               cur_row_in   = ord_row;
               res_in       = ord_res;
            end
         end
         ST_SGR: begin
            // one parameter slot per cycle through the SGR unit
            pctl.walk_en = 1'b1;
            sgr_in       = sgr_next;
            res_in       = '0;
            if (walk_last) begin
               pctl.clear   = 1'b1;
               in_escape_in = 1'b0;
               in_csi_in    = 1'b0;
               state_in     = ST_RESP;
            end else begin
               walk_idx_in = walk_idx_ff + IDX_W'(1);
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // shadow of the slot count, tracked from the same controls
      if (pctl.clear) begin
         walk_count_in = SU_W'(1);
      end else if (pctl.semi_en && walk_count_ff != SU_W'(PARAM_SLOTS)) begin
         walk_count_in = walk_count_ff + SU_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         walk_idx_ff     <= '0;
         walk_count_ff   <= SU_W'(1);
         in_escape_ff    <= 1'b0;
         in_csi_ff       <= 1'b0;
         sgr_ff.attr     <= ATTR_INIT;
         sgr_ff.bold     <= 1'b0;
         sgr_ff.blink    <= 1'b0;
         cur_col_ff      <= '0;
         cur_row_ff      <= '0;
         default_attr_ff <= ATTR_INIT;
         tab_step_ff     <= TAB_INIT;
      end else begin
         state_ff        <= state_in;
         walk_idx_ff     <= walk_idx_in;
         walk_count_ff   <= walk_count_in;
         in_escape_ff    <= in_escape_in;
         in_csi_ff       <= in_csi_in;
         sgr_ff          <= sgr_in;
         cur_col_ff      <= cur_col_in;
         cur_row_ff      <= cur_row_in;
         default_attr_ff <= default_attr_in;
         tab_step_ff     <= tab_step_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      res_ff  <= res_in;
   end

endmodule

### sv/atte_param_regs.sv
// CSI parameter slots: saturating decimal accumulate, slot advance, three read ports.
module atte_param_regs import atte_pkg::*; #(
   parameter int  PARAM_SLOTS = 10,
   localparam int IDX_W       = $clog2(PARAM_SLOTS),
   localparam int SU_W        = $clog2(PARAM_SLOTS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  param_ctrl_type      ctrl,
   input  logic [IDX_W-1:0]    walk_idx,
   output logic [PARAM_W-1:0]  rd_value,
   output logic [PARAM_W-1:0]  first_value,
   output logic [PARAM_W-1:0]  second_value
);

   localparam int ACC_W = PARAM_W + 4;

   logic [PARAM_W-1:0] values_ff [PARAM_SLOTS];
   logic [PARAM_W-1:0] values_in [PARAM_SLOTS];
   logic [SU_W-1:0]    slots_ff;
   logic [SU_W-1:0]    slots_in;
   logic [IDX_W-1:0]   slot;
   logic [IDX_W-1:0]   rd_addr;
   logic [ACC_W-1:0]   acc;
   logic [PARAM_W-1:0] acc_sat;

   assign slot    = IDX_W'(slots_ff - SU_W'(1));
   assign rd_addr = ctrl.walk_en ? walk_idx : slot;
   assign rd_value     = values_ff[rd_addr];
   assign first_value  = values_ff[0];
   assign second_value = values_ff[1];

   // value * 10 + digit as shift-add
   assign acc = ({{(ACC_W-PARAM_W){1'b0}}, rd_value} << 3)
              + ({{(ACC_W-PARAM_W){1'b0}}, rd_value} << 1)
              + {{(ACC_W-DIGIT_W){1'b0}}, ctrl.digit};
   assign acc_sat = (acc > {{(ACC_W-PARAM_W){1'b0}}, PARAM_MAX}) ? PARAM_MAX
                                                                  : acc[PARAM_W-1:0];

   always_comb begin
      for (int i = 0; i < PARAM_SLOTS; i++) begin
         if (ctrl.clear) begin
            values_in[i] = '0;
         end else if (ctrl.digit_en && (slot == IDX_W'(i))) begin
            values_in[i] = acc_sat;
         end else begin
            values_in[i] = values_ff[i];
         end
      end
      slots_in = slots_ff;
      if (ctrl.clear) begin
         slots_in = SU_W'(1);
      end else if (ctrl.semi_en && (slots_ff != SU_W'(PARAM_SLOTS))) begin
         slots_in = slots_ff + SU_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PARAM_SLOTS; i++) begin
            values_ff[i] <= '0;
         end
         slots_ff <= SU_W'(1);
      end else begin
         values_ff <= values_in;
         slots_ff  <= slots_in;
      end
   end

endmodule

### sv/atte_sgr_unit.sv
// SGR step: applies one select-graphic-rendition code to the attribute state.
module atte_sgr_unit import atte_pkg::*; (
   input  logic [PARAM_W-1:0] value,
   input  sgr_state_type      cur,
   input  logic [ATTR_W-1:0]  default_attr,
   output sgr_state_type      nxt
);

   localparam logic [PARAM_W-1:0] SGR_RESET     = 16'd0;
   localparam logic [PARAM_W-1:0] SGR_BOLD      = 16'd1;
   localparam logic [PARAM_W-1:0] SGR_BLINK     = 16'd5;
   localparam logic [PARAM_W-1:0] SGR_NO_BOLD   = 16'd22;
   localparam logic [PARAM_W-1:0] SGR_NO_BLINK  = 16'd25;
   localparam logic [PARAM_W-1:0] SGR_FG_FIRST  = 16'd30;
   localparam logic [PARAM_W-1:0] SGR_FG_LAST   = 16'd37;
   localparam logic [PARAM_W-1:0] SGR_BG_FIRST  = 16'd40;
   localparam logic [PARAM_W-1:0] SGR_BG_LAST   = 16'd47;

   logic [PARAM_W-1:0] off_fg;
   logic [PARAM_W-1:0] off_bg;
   logic [3:0]         fg;
   logic [3:0]         bg_color;
   logic [2:0]         bg;

   assign off_fg = value - SGR_FG_FIRST;
   assign off_bg = value - SGR_BG_FIRST;

   always_comb begin
      nxt      = cur;
      fg       = 4'h7;
      bg       = 3'h0;
      bg_color = sgr_color(off_bg[2:0]);
      if (value == SGR_RESET) begin
         nxt.attr  = default_attr;
         nxt.bold  = 1'b0;
         nxt.blink = 1'b0;
      end else if (value == SGR_BOLD) begin
         nxt.bold = 1'b1;
      end else if (value == SGR_BLINK) begin
         nxt.blink = 1'b1;
      end else if (value == SGR_NO_BOLD) begin
         nxt.bold = 1'b0;
      end else if (value == SGR_NO_BLINK) begin
         nxt.blink = 1'b0;
      end else if (value >= SGR_FG_FIRST && value <= SGR_BG_LAST) begin
         if (value <= SGR_FG_LAST) begin
            fg = sgr_color(off_fg[2:0]) | {cur.bold, 3'b000};
         end else if (value >= SGR_BG_FIRST) begin
            bg = bg_color[2:0];
         end
         nxt.attr = {cur.blink, bg, fg};
      end
   end

endmodule

### sim/tb_ansi_text_terminal_engine_unit.sv
// Testbench for the ANSI text terminal engine: directed and random escape and text traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_ansi_text_terminal_engine_unit;
   import atte_pkg::*;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int PARAM_SLOTS = 10;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned MAX_REPORTS    = 40;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_ATTR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAB_STEP     = 1'd1;

   // Character codes
   localparam int unsigned CH_NUL      = 9'h000;
   localparam int unsigned CH_BS       = 9'h008;
   localparam int unsigned CH_TAB      = 9'h009;
   localparam int unsigned CH_LF       = 9'h00A;
   localparam int unsigned CH_CR       = 9'h00D;
   localparam int unsigned CH_ESC      = 9'h01B;
   localparam int unsigned CH_SPACE    = 9'h020;
   localparam int unsigned CH_TILDE    = 9'h07E;
   localparam int unsigned CH_ZERO     = 9'h030;
   localparam int unsigned CH_NINE     = 9'h039;
   localparam int unsigned CH_SEMI     = 9'h03B;
   localparam int unsigned CH_CSI      = 9'h05B;
   localparam int unsigned CH_LEFT     = 9'h0E4;
   localparam int unsigned CH_RIGHT    = 9'h0E5;
   localparam int unsigned CH_DELETE   = 9'h0E9;
   localparam int unsigned CH_TOP_BYTE = 9'h0FF;
   localparam int unsigned CH_ERASE    = 9'h100;
   localparam int unsigned CODE_TOP    = 9'h1FF;

   // Control sequence finals
   localparam int unsigned FIN_UP    = "A";
   localparam int unsigned FIN_DOWN  = "B";
   localparam int unsigned FIN_RIGHT = "C";
   localparam int unsigned FIN_LEFT  = "D";
   localparam int unsigned FIN_PLACE = "H";
   localparam int unsigned FIN_CLEAR = "J";
   localparam int unsigned FIN_SGR   = "m";
   localparam int unsigned ERASE_ALL = 2;

   // SGR codes
   localparam int unsigned SGR_RESET    = 0;
   localparam int unsigned SGR_BOLD     = 1;
   localparam int unsigned SGR_BLINK    = 5;
   localparam int unsigned SGR_NORMAL   = 22;
   localparam int unsigned SGR_STEADY   = 25;
   localparam int unsigned SGR_FG_FIRST = 30;
   localparam int unsigned SGR_FG_LAST  = 37;
   localparam int unsigned SGR_BG_FIRST = 40;
   localparam int unsigned SGR_BG_LAST  = 47;
   localparam int unsigned ARG_LIMIT    = 65535;

   localparam logic [3:0] VGA_PALETTE [8] = '{4'h0, 4'h4, 4'h2, 4'hE, 4'h1, 4'h5, 4'h3, 4'h7};
   localparam int unsigned EDIT_KEYS [8] =
      '{CH_ERASE, CH_BS, CH_LEFT, CH_RIGHT, CH_DELETE, CH_LF, CH_CR, CH_TAB};
   localparam int unsigned MOVE_FINALS [4] = '{FIN_UP, FIN_DOWN, FIN_RIGHT, FIN_LEFT};
   localparam int unsigned SGR_FLAGS [5] =
      '{SGR_RESET, SGR_BOLD, SGR_BLINK, SGR_NORMAL, SGR_STEADY};
   localparam int unsigned PHASE_END [4] = '{450, 850, 1200, 1450};

   typedef struct packed {
      logic              cell_write;
      logic [ROW_W-1:0]  cell_row;
      logic [COL_W-1:0]  cell_col;
      logic [7:0]        cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic              scroll_up;
      logic              clear_screen;
      logic [ROW_W-1:0]  cursor_row_out;
      logic [COL_W-1:0]  cursor_col_out;
   } screen_update_type;

   class terminal_scoreboard;
      screen_update_type update_q[$];
      int unsigned       errors;
      int unsigned       checked;

      logic [ATTR_W-1:0]  default_attr;
      logic [TAB_W-1:0]   tab_step;
      bit                 in_escape;
      bit                 in_csi;
      logic [PARAM_W-1:0] csi_args [PARAM_SLOTS];
      int unsigned        args_used;
      logic [ATTR_W-1:0]  text_attr;
      bit                 bold;
      bit                 blink;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;

      function new();
         default_attr = 8'h07;
         tab_step     = 4'd4;
         in_escape    = 1'b0;
         in_csi       = 1'b0;
         text_attr    = 8'h07;
         bold         = 1'b0;
         blink        = 1'b0;
         col          = '0;
         row          = '0;
         errors       = 0;
         checked      = 0;
         clear_args();
      endfunction

      function void clear_args();
         foreach (csi_args[i]) csi_args[i] = '0;
         args_used = 1;
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] value);
         if (idx == REG_DEFAULT_ATTR) begin
            default_attr = value;
         end else if (idx == REG_TAB_STEP) begin
            tab_step = value[TAB_W-1:0];
         end
      endfunction

      function int unsigned pending();
         return update_q.size();
      endfunction

      // Work out the screen update for one accepted request.
      function void note_request(input int unsigned code);
         screen_update_type upd;
         int unsigned       slot;
         int unsigned       v;
         int unsigned       i;
         logic [3:0]        fg;
         logic [3:0]        bg;
         bit                wr;
         logic [ROW_W-1:0]  wrow;
         logic [COL_W-1:0]  wcol;
         logic [7:0]        wch;

         upd  = '0;
         wr   = 1'b0;
         wrow = '0;
         wcol = '0;
         wch  = '0;
         if (code > CH_ERASE) begin
            // drop: no state change
         end else if (code == CH_ESC) begin
            clear_args();
            in_escape = 1'b1;
            in_csi    = 1'b0;
         end else if (in_escape && code == CH_CSI) begin
            clear_args();
            in_csi = 1'b1;
         end else if (in_escape && in_csi) begin
            slot = args_used - 1;
            if (code >= CH_ZERO && code <= CH_NINE) begin
               v = csi_args[slot] * 10 + (code - CH_ZERO);
               csi_args[slot] = (v > ARG_LIMIT) ? PARAM_W'(ARG_LIMIT) : PARAM_W'(v);
            end else if (code == CH_SEMI) begin
               if (args_used < PARAM_SLOTS) args_used++;
            end else begin
               case (code)
                  FIN_UP: if (row > 0) row--;
                  FIN_DOWN: if (row < ROWS - 1) row++;
                  FIN_RIGHT: if (col < COLUMNS - 1) col++;
                  FIN_LEFT: if (col > 0) col--;
                  FIN_PLACE: begin
                     row = (csi_args[0] > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(csi_args[0]);
                     col = (csi_args[1] > COLUMNS - 1) ? COL_W'(COLUMNS - 1)
                                                       : COL_W'(csi_args[1]);
                  end
                  FIN_CLEAR: begin
                     if (csi_args[0] == ERASE_ALL) begin
                        upd.clear_screen = 1'b1;
                        row = '0;
                        col = '0;
                     end
                  end
                  FIN_SGR: begin
                     for (i = 0; i < args_used; i++) begin
                        v = csi_args[i];
                        if (v == SGR_RESET) begin
                           text_attr = default_attr;
                           bold      = 1'b0;
                           blink     = 1'b0;
                        end else if (v == SGR_BOLD) begin
                           bold = 1'b1;
                        end else if (v == SGR_BLINK) begin
                           blink = 1'b1;
                        end else if (v == SGR_NORMAL) begin
                           bold = 1'b0;
                        end else if (v == SGR_STEADY) begin
                           blink = 1'b0;
                        end else if (v >= SGR_FG_FIRST && v <= SGR_BG_LAST) begin
                           fg = 4'h7;
                           bg = 4'h0;
                           if (v <= SGR_FG_LAST) begin
                              fg = VGA_PALETTE[3'(v - SGR_FG_FIRST)];
                              if (bold) fg = fg | 4'h8;
                           end else if (v >= SGR_BG_FIRST) begin
                              bg = VGA_PALETTE[3'(v - SGR_BG_FIRST)];
                           end
                           text_attr = {blink, bg[2:0], fg};
                        end
                     end
                  end
                  default: ;
               endcase
               clear_args();
               in_escape = 1'b0;
               in_csi    = 1'b0;
            end
         end else begin
            in_escape = 1'b0;
            in_csi    = 1'b0;
            if (code == CH_ERASE) begin
               if (col > 0) begin
                  col--;
                  // erasing into column 0 jumps to the end of the row above
                  if (col == 0 && row > 0) begin
                     col = COL_W'(COLUMNS - 1);
                     row--;
                  end
                  wr  = 1'b1;
                  wch = 8'(CH_SPACE);
               end
            end else if (code == CH_LEFT) begin
               if (col > 0) col--;
            end else if (code == CH_RIGHT) begin
               if (col < COLUMNS - 1) col++;
            end else if (code == CH_DELETE) begin
               wr  = 1'b1;
               wch = 8'(CH_SPACE);
            end else if (code == CH_LF || code == CH_CR) begin
               col = '0;
               row++;
            end else if (code == CH_TAB) begin
               col = col + COL_W'(tab_step);
               if (col >= COLUMNS) begin
                  col = '0;
                  row++;
               end
            end else if (code == CH_BS) begin
               if (col > 0) col--;
               wr  = 1'b1;
               wch = 8'(CH_SPACE);
            end else begin
               wr   = 1'b1;
               wch  = code[7:0];
               wrow = row;
               wcol = col;
               col++;
               if (col >= COLUMNS) begin
                  col = '0;
                  row++;
               end
            end
            // blanking keys write at the cursor after it moved
            if (wr && wch == CH_SPACE && code != CH_SPACE) begin
               wrow = row;
               wcol = col;
            end
            if (wr) begin
               upd.cell_write = 1'b1;
               upd.cell_row   = wrow;
               upd.cell_col   = wcol;
               upd.cell_char  = wch;
               upd.cell_attr  = text_attr;
            end
            if (row >= ROWS) begin
               upd.scroll_up = 1'b1;
               row = ROW_W'(ROWS - 1);
            end
         end
         upd.cursor_row_out = row;
         upd.cursor_col_out = col;
         update_q.push_back(upd);
      endfunction

      task report_mismatch(input string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("MISMATCH %s", msg);
      endtask

      task check_response(input screen_update_type got);
         screen_update_type want;
         checked++;
         if (update_q.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing expected", checked));
            return;
         end
         want = update_q.pop_front();
         if (got.cell_write !== want.cell_write)
            report_mismatch($sformatf("response %0d cell_write %0h, want %0h",
                                      checked, got.cell_write, want.cell_write));
         if (got.cell_row !== want.cell_row)
            report_mismatch($sformatf("response %0d cell_row %0d, want %0d",
                                      checked, got.cell_row, want.cell_row));
         if (got.cell_col !== want.cell_col)
            report_mismatch($sformatf("response %0d cell_col %0d, want %0d",
                                      checked, got.cell_col, want.cell_col));
         if (got.cell_char !== want.cell_char)
            report_mismatch($sformatf("response %0d cell_char %0h, want %0h",
                                      checked, got.cell_char, want.cell_char));
         if (got.cell_attr !== want.cell_attr)
            report_mismatch($sformatf("response %0d cell_attr %0h, want %0h",
                                      checked, got.cell_attr, want.cell_attr));
         if (got.scroll_up !== want.scroll_up)
            report_mismatch($sformatf("response %0d scroll_up %0h, want %0h",
                                      checked, got.scroll_up, want.scroll_up));
         if (got.clear_screen !== want.clear_screen)
            report_mismatch($sformatf("response %0d clear_screen %0h, want %0h",
                                      checked, got.clear_screen, want.clear_screen));
         if (got.cursor_row_out !== want.cursor_row_out)
            report_mismatch($sformatf("response %0d cursor_row_out %0d, want %0d",
                                      checked, got.cursor_row_out, want.cursor_row_out));
         if (got.cursor_col_out !== want.cursor_col_out)
            report_mismatch($sformatf("response %0d cursor_col_out %0d, want %0d",
                                      checked, got.cursor_col_out, want.cursor_col_out));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   atte_req_if req_if ();
   atte_rsp_if rsp_if ();

   terminal_scoreboard board;
   bit                 calm = 1'b0;
   int unsigned        chars_sent = 0;
   int unsigned        stall_left = 0;
   int unsigned        quiet_cycles = 0;

   ansi_text_terminal_engine_unit #(
      .COLUMNS     (COLUMNS),
      .ROWS        (ROWS),
      .PARAM_SLOTS (PARAM_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Response side: check each taken response, stall ready in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         board.check_response({rsp_if.cell_write, rsp_if.cell_row, rsp_if.cell_col,
                               rsp_if.cell_char, rsp_if.cell_attr, rsp_if.scroll_up,
                               rsp_if.clear_screen, rsp_if.cursor_row_out,
                               rsp_if.cursor_col_out});
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_char(input int unsigned code);
      int unsigned gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_code <= CHAR_W'(code);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_request(code);
      if (code <= CH_ERASE) chars_sent++;
   endtask

   task automatic send_arg(input int unsigned value);
      string digits;
      int    i;
      digits = $sformatf("%0d", value);
      for (i = 0; i < digits.len(); i++) send_char(digits[i]);
   endtask

   // Hold off new requests until every response has been taken.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] attr,
                            input logic [CSR_DATA_W-1:0] tab);
      csr_we    <= 1'b1;
      csr_index <= REG_DEFAULT_ATTR;
      csr_wdata <= attr;
      @(posedge clock);
      board.write_register(REG_DEFAULT_ATTR, attr);
      csr_index <= REG_TAB_STEP;
      csr_wdata <= tab;
      @(posedge clock);
      board.write_register(REG_TAB_STEP, tab);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_sequence();
      int unsigned kind;
      int unsigned n;
      int unsigned i;
      int unsigned code;
      int unsigned arg;
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
         n = $urandom_range(1, 12);
         for (i = 0; i < n; i++) begin
            send_char(($urandom_range(0, 3) == 0) ? $urandom_range(0, CH_TOP_BYTE)
                                                  : $urandom_range(CH_SPACE, CH_TILDE));
         end
      end else if (kind < 42) begin
         // bursts of one key walk into wraps and scrolls
         code = EDIT_KEYS[$urandom_range(0, 7)];
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) send_char(code);
      end else if (kind < 54) begin
         send_char(CH_ESC);
         send_char(CH_CSI);
         if ($urandom_range(0, 3) == 0) send_arg($urandom_range(0, 99));
         send_char(MOVE_FINALS[$urandom_range(0, 3)]);
      end else if (kind < 64) begin
         send_char(CH_ESC);
         send_char(CH_CSI);
         if ($urandom_range(0, 5) != 0) begin
            send_arg(($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000)
                                                 : $urandom_range(0, ROWS + 4));
         end
         if ($urandom_range(0, 5) != 0) begin
            send_char(CH_SEMI);
            send_arg(($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000)
                                                 : $urandom_range(0, COLUMNS + 9));
         end
         send_char(FIN_PLACE);
      end else if (kind < 80) begin
         send_char(CH_ESC);
         send_char(CH_CSI);
         n = $urandom_range(1, PARAM_SLOTS + 2);
         for (i = 0; i < n; i++) begin
            if (i > 0) send_char(CH_SEMI);
            case ($urandom_range(0, 5))
               0: arg = SGR_FLAGS[$urandom_range(0, 4)];
               1, 2: arg = $urandom_range(SGR_FG_FIRST, SGR_BG_LAST);
               3, 4: arg = $urandom_range(0, 99);
               default: arg = $urandom_range(0, 70000);
            endcase
            // leave some arguments empty
            if ($urandom_range(0, 7) != 0) send_arg(arg);
         end
         send_char(FIN_SGR);
      end else if (kind < 86) begin
         send_char(CH_ESC);
         send_char(CH_CSI);
         send_arg(($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : ERASE_ALL);
         send_char(FIN_CLEAR);
      end else if (kind < 94) begin
         send_char(CH_ESC);
         case ($urandom_range(0, 3))
            0: send_char($urandom_range(0, CH_TOP_BYTE));
            1: begin
               send_char(CH_CSI);
               send_arg($urandom_range(0, 999));
               send_char(CH_ESC);
            end
            2: begin
               send_char(CH_CSI);
               send_arg($urandom_range(0, 99));
               send_char(CH_CSI);
               send_arg($urandom_range(0, 99));
               send_char(MOVE_FINALS[$urandom_range(0, 3)]);
            end
            default: begin
               send_char(CH_CSI);
               send_arg($urandom_range(0, 99));
               send_char($urandom_range(0, CH_TOP_BYTE));
            end
         endcase
      end else begin
         send_char($urandom_range(0, CODE_TOP));
      end
   endtask

   initial begin
      int unsigned directed [$];
      int          phase;

      board = new();
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.char_code <= '0;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      directed = '{CH_NUL, CH_TOP_BYTE, CODE_TOP, CH_ERASE,
                   CH_ESC, CH_CSI, "9", "9", "9", "9", "9", FIN_PLACE,
                   "x", CH_ESC, "q", CH_BS, CH_LEFT, CH_RIGHT, CH_DELETE, CH_TAB, CH_LF,
                   CH_ESC, CH_CSI, "2", FIN_CLEAR};
      foreach (directed[i]) send_char(directed[i]);

      for (phase = 0; phase < 4; phase++) begin
         wait_drained();
         case (phase)
            0: configure(8'h00, 8'd1);
            1: configure(8'hFF, 8'd8);
            2: configure(8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)));
            default: begin
               configure(8'h07, 8'd4);
               calm = 1'b1;
            end
         endcase
         while (chars_sent < PHASE_END[phase]) send_random_sequence();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
sv/atte_pkg.sv
sv/atte_if.sv
sv/atte_param_regs.sv
sv/atte_sgr_unit.sv
sv/ansi_text_terminal_engine_unit.sv
sim/tb_ansi_text_terminal_engine_unit.sv
